### src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression never true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### src/dtfp_pkg.sv
`default_nettype none

package dtfp_pkg;

	localparam int CHAR_BITS     = 16;
	localparam int BLANK_MAX     = 32;
	localparam int DELIM_RESET   = 44;
	localparam int QUOTE_RESET   = 34;
	localparam int QUEUE_DEPTH   = 4;
	localparam int CFG_ADDR_BITS = 4;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [1:0] REG_DELIM  = 2'd0;
	localparam logic [1:0] REG_QUOTE  = 2'd1;
	localparam logic [1:0] REG_STRICT = 2'd2;

	typedef enum logic [1:0] {
		K_CHAR = 2'd0,
		K_EOF  = 2'd1,
		K_EOT  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		P_START        = 4'd0,
		PL_UNQ         = 4'd1,
		PL_QUOTED      = 4'd2,
		PL_QPEND       = 4'd3,
		PL_AFTER_FIELD = 4'd4,
		PL_AFTER_DELIM = 4'd5,
		PL_STOPPED     = 4'd6,
		PS_FBEGIN      = 4'd7,
		PS_UNQ         = 4'd8,
		PS_QUOTED      = 4'd9,
		PS_QPEND       = 4'd10,
		PS_SKIP        = 4'd11
	} phase_t;

	typedef struct packed {
		logic                 op;
		logic [CHAR_BITS-1:0] ch;
	} dtfp_in_t;

	typedef struct packed {
		kind_t                kind;
		logic [CHAR_BITS-1:0] field_char;
		logic                 last;
	} dtfp_out_t;

	// One queue entry: first result, and whether an end-of-text mark follows it.
	typedef struct packed {
		logic                 two;
		kind_t                kind0;
		logic [CHAR_BITS-1:0] char0;
	} dtfp_ent_t;

	typedef struct packed {
		logic empty;
		logic full;
	} dtfp_qstat_t;

endpackage

`default_nettype wire

### src/dtfp_queue.sv
`default_nettype none

module dtfp_queue #(
	parameter int DEPTH = dtfp_pkg::QUEUE_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  dtfp_pkg::dtfp_ent_t   push_data,
	input  wire                   pop,
	output dtfp_pkg::dtfp_ent_t   head,
	output dtfp_pkg::dtfp_qstat_t qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dtfp_pkg::dtfp_ent_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head        = mem_q[rd_ptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == CW'(DEPTH));

`include "assert_macros.svh"

	`ASSERT_NEVER(a_q_overflow, clk, arst_n, push && qstat.full, "queue push while full")
	`ASSERT_NEVER(a_q_underflow, clk, arst_n, pop && qstat.empty, "queue pop while empty")

endmodule

`default_nettype wire

### src/dtfp_front.sv
`default_nettype none

module dtfp_front (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 char_valid,
	output logic                                char_stall,
	input  dtfp_pkg::dtfp_in_t                  char_word,
	input  wire  [dtfp_pkg::CHAR_BITS-1:0]      delimiter,
	input  wire  [dtfp_pkg::CHAR_BITS-1:0]      quote_char,
	input  wire                                 strict_mode,
	input  dtfp_pkg::dtfp_qstat_t               qstat,
	output logic                                push,
	output dtfp_pkg::dtfp_ent_t                 push_data
);

	dtfp_pkg::phase_t phase_q;
	dtfp_pkg::phase_t phase_d;

	logic accept;
	logic is_end;
	logic is_blank;
	logic is_quote;
	logic is_delim;
	logic emit;
	logic two;
	dtfp_pkg::kind_t kind0;

	assign char_stall = qstat.full;
	assign accept     = char_valid && !qstat.full;
	assign is_end     = char_word.op || (char_word.ch == '0);
	assign is_blank   = (char_word.ch != '0) &&
		(char_word.ch <= dtfp_pkg::CHAR_BITS'(dtfp_pkg::BLANK_MAX));
	assign is_quote   = (quote_char != '0) && (char_word.ch == quote_char);
	assign is_delim   = (char_word.ch == delimiter);

	always_comb begin
		phase_d = phase_q;
		if (is_end) begin
			phase_d = dtfp_pkg::P_START;
		end else begin
			unique case (phase_q) inside
				dtfp_pkg::P_START: begin
					if (strict_mode) begin
						phase_d = is_quote ? dtfp_pkg::PS_QUOTED :
							is_delim ? dtfp_pkg::PS_FBEGIN : dtfp_pkg::PS_UNQ;
					end else if (!is_blank) begin
						phase_d = is_quote ? dtfp_pkg::PL_QUOTED :
							is_delim ? dtfp_pkg::PL_AFTER_DELIM : dtfp_pkg::PL_UNQ;
					end
				end
				dtfp_pkg::PL_AFTER_DELIM: begin
					if (!is_blank) begin
						phase_d = is_quote ? dtfp_pkg::PL_QUOTED :
							is_delim ? dtfp_pkg::PL_AFTER_DELIM : dtfp_pkg::PL_UNQ;
					end
				end
				dtfp_pkg::PL_UNQ: begin
					if (is_blank) begin
						phase_d = dtfp_pkg::PL_AFTER_FIELD;
					end else if (is_delim) begin
						phase_d = dtfp_pkg::PL_AFTER_DELIM;
					end
				end
				dtfp_pkg::PL_QUOTED: begin
					if (is_quote) begin
						phase_d = dtfp_pkg::PL_QPEND;
					end
				end
				dtfp_pkg::PS_QUOTED: begin
					if (is_quote) begin
						phase_d = dtfp_pkg::PS_QPEND;
					end
				end
				dtfp_pkg::PL_QPEND, dtfp_pkg::PL_AFTER_FIELD: begin
					if (phase_q == dtfp_pkg::PL_QPEND && is_quote) begin
						phase_d = dtfp_pkg::PL_QUOTED;
					end else if (is_blank) begin
						phase_d = dtfp_pkg::PL_AFTER_FIELD;
					end else if (is_delim) begin
						phase_d = dtfp_pkg::PL_AFTER_DELIM;
					end else begin
						phase_d = dtfp_pkg::PL_STOPPED;
					end
				end
				dtfp_pkg::PS_FBEGIN: begin
					phase_d = is_quote ? dtfp_pkg::PS_QUOTED :
						is_delim ? dtfp_pkg::PS_FBEGIN : dtfp_pkg::PS_UNQ;
				end
				dtfp_pkg::PS_UNQ: begin
					if (is_delim) begin
						phase_d = dtfp_pkg::PS_FBEGIN;
					end
				end
				dtfp_pkg::PS_QPEND: begin
					phase_d = is_quote ? dtfp_pkg::PS_QUOTED :
						is_delim ? dtfp_pkg::PS_FBEGIN : dtfp_pkg::PS_SKIP;
				end
				dtfp_pkg::PS_SKIP: begin
					if (is_delim) begin
						phase_d = dtfp_pkg::PS_FBEGIN;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	always_comb begin
		emit  = 1'b0;
		two   = 1'b0;
		kind0 = dtfp_pkg::K_CHAR;
		if (is_end) begin
			emit = 1'b1;
			if (phase_q != dtfp_pkg::P_START && phase_q != dtfp_pkg::PL_AFTER_FIELD &&
				phase_q != dtfp_pkg::PL_STOPPED) begin
				two   = 1'b1;
				kind0 = dtfp_pkg::K_EOF;
			end else begin
				kind0 = dtfp_pkg::K_EOT;
			end
		end else begin
			unique case (phase_q) inside
				dtfp_pkg::P_START, dtfp_pkg::PL_AFTER_DELIM, dtfp_pkg::PS_FBEGIN: begin
					if (!is_quote && (phase_q == dtfp_pkg::PS_FBEGIN || !is_blank ||
						(phase_q == dtfp_pkg::P_START && strict_mode))) begin
						emit  = 1'b1;
						kind0 = is_delim ? dtfp_pkg::K_EOF : dtfp_pkg::K_CHAR;
					end
				end
				dtfp_pkg::PL_UNQ: begin
					emit  = 1'b1;
					kind0 = (is_blank || is_delim) ? dtfp_pkg::K_EOF : dtfp_pkg::K_CHAR;
				end
				dtfp_pkg::PL_QUOTED, dtfp_pkg::PS_QUOTED: begin
					emit  = !is_quote;
					kind0 = dtfp_pkg::K_CHAR;
				end
				dtfp_pkg::PL_QPEND: begin
					emit  = 1'b1;
					kind0 = is_quote ? dtfp_pkg::K_CHAR : dtfp_pkg::K_EOF;
				end
				dtfp_pkg::PS_UNQ: begin
					emit  = 1'b1;
					kind0 = is_delim ? dtfp_pkg::K_EOF : dtfp_pkg::K_CHAR;
				end
				dtfp_pkg::PS_QPEND: begin
					emit  = is_quote || is_delim;
					kind0 = is_quote ? dtfp_pkg::K_CHAR : dtfp_pkg::K_EOF;
				end
				dtfp_pkg::PS_SKIP: begin
					emit  = is_delim;
					kind0 = dtfp_pkg::K_EOF;
				end
				default: emit = 1'b0;
			endcase
		end
	end

	assign push            = accept && emit;
	assign push_data.two   = two;
	assign push_data.kind0 = kind0;
	assign push_data.char0 = (kind0 == dtfp_pkg::K_CHAR) ? char_word.ch : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dtfp_pkg::P_START;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

`include "assert_macros.svh"

	`ASSERT_CLK(a_end_restarts, clk, arst_n, accept && is_end |=> phase_q == dtfp_pkg::P_START, "no restart")
	`ASSERT_NEVER(a_two_only_at_end, clk, arst_n, push && push_data.two && !is_end, "two words mid-text")

endmodule

`default_nettype wire

### src/dtfp_back.sv
`default_nettype none

module dtfp_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  dtfp_pkg::dtfp_ent_t   head,
	input  dtfp_pkg::dtfp_qstat_t qstat,
	output logic                  pop,
	output logic                  field_valid,
	input  wire                   field_stall,
	output dtfp_pkg::dtfp_out_t   field_word
);

	logic                load;
	logic                sub_q;
	logic                valid_q;
	dtfp_pkg::dtfp_out_t word_q;
	dtfp_pkg::dtfp_out_t next_word;

	assign load = !valid_q || !field_stall;
	assign pop  = load && !qstat.empty && (sub_q || !head.two);

	always_comb begin
		if (sub_q) begin
			next_word.kind       = dtfp_pkg::K_EOT;
			next_word.field_char = '0;
			next_word.last       = 1'b1;
		end else begin
			next_word.kind       = head.kind0;
			next_word.field_char = head.char0;
			next_word.last       = !head.two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else if (load) begin
			valid_q <= !qstat.empty;
			if (!qstat.empty) begin
				sub_q <= !sub_q && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !qstat.empty) begin
			word_q <= next_word;
		end
	end

	assign field_valid = valid_q;
	assign field_word  = word_q;

`include "assert_macros.svh"

	`ASSERT_NEVER(a_sub_needs_head, clk, arst_n, sub_q && qstat.empty, "pending end mark without queue entry")
	`ASSERT_CLK(a_sub_follows_eof, clk, arst_n, $rose(sub_q) |-> valid_q && field_word.kind == dtfp_pkg::K_EOF, "end-of-text mark not preceded by end of field")

endmodule

`default_nettype wire

### src/delimited_text_field_parser_top.sv
// Delimited text field parser: takes one 16-bit character word per cycle (op 1 or a zero
// character ends the text) and streams out field characters, end-of-field marks and an
// end-of-text mark, with last set on the final word caused by each input word. Input and
// output run at one word per cycle each while not stalled; an end of text that closes an
// open field yields two output words. A queue of QUEUE_DEPTH entries between the parsing
// state machine and the output register absorbs that and lets either side stall; input
// stall rises only when the queue is full. Words pass a queue entry and then the output
// register. Registers (APB, byte addresses 0, 4, 8): delimiter, quote character (0 turns
// quoting off), strict mode; write them only while the block is idle. Strict mode is taken
// at the first character of a text; delimiter and quote changes act at once.
`default_nettype none

module delimited_text_field_parser_top #(
	parameter int QUEUE_DEPTH = dtfp_pkg::QUEUE_DEPTH
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    char_valid,
	output logic                                   char_stall,
	input  dtfp_pkg::dtfp_in_t                     char_word,
	output logic                                   field_valid,
	input  wire                                    field_stall,
	output dtfp_pkg::dtfp_out_t                    field_word,
	input  wire                                    psel,
	input  wire                                    penable,
	input  wire                                    pwrite,
	input  wire  [dtfp_pkg::CFG_ADDR_BITS-1:0]     paddr,
	input  wire  [dtfp_pkg::CFG_DATA_BITS-1:0]     pwdata,
	output logic [dtfp_pkg::CFG_DATA_BITS-1:0]     prdata,
	output logic                                   pready
);

	logic [dtfp_pkg::CHAR_BITS-1:0] delim_q;
	logic [dtfp_pkg::CHAR_BITS-1:0] quote_q;
	logic                           strict_q;
	logic                           cfg_wr;
	logic [1:0]                     reg_sel;

	logic                  push;
	logic                  pop;
	dtfp_pkg::dtfp_ent_t   push_data;
	dtfp_pkg::dtfp_ent_t   head;
	dtfp_pkg::dtfp_qstat_t qstat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q  <= dtfp_pkg::CHAR_BITS'(dtfp_pkg::DELIM_RESET);
			quote_q  <= dtfp_pkg::CHAR_BITS'(dtfp_pkg::QUOTE_RESET);
			strict_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				dtfp_pkg::REG_DELIM:  delim_q  <= pwdata[dtfp_pkg::CHAR_BITS-1:0];
				dtfp_pkg::REG_QUOTE:  quote_q  <= pwdata[dtfp_pkg::CHAR_BITS-1:0];
				dtfp_pkg::REG_STRICT: strict_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			dtfp_pkg::REG_DELIM:  prdata = dtfp_pkg::CFG_DATA_BITS'(delim_q);
			dtfp_pkg::REG_QUOTE:  prdata = dtfp_pkg::CFG_DATA_BITS'(quote_q);
			dtfp_pkg::REG_STRICT: prdata = dtfp_pkg::CFG_DATA_BITS'(strict_q);
			default:              prdata = '0;
		endcase
	end

	dtfp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_word   (char_word),
		.delimiter   (delim_q),
		.quote_char  (quote_q),
		.strict_mode (strict_q),
		.qstat       (qstat),
		.push        (push),
		.push_data   (push_data)
	);

	dtfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	dtfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.field_valid (field_valid),
		.field_stall (field_stall),
		.field_word  (field_word)
	);

endmodule

`default_nettype wire
